[design/pwroc_pkg.sv]
// Package for the power output controller: item kinds, register indexes,
// field widths, reset values of the registers and timing constants.
// No dependencies.
package pwroc_pkg;

  typedef enum logic [1:0] {
    ACT_CONTROL = 2'd0,
    ACT_KEYPAD  = 2'd1,
    ACT_TRIM    = 2'd2,
    ACT_UNUSED  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    REG_IGN_ON    = 3'd0,
    REG_IGN_OFF   = 3'd1,
    REG_OVERVOLT  = 3'd2,
    REG_HOT_SET   = 3'd3,
    REG_HOT_CLEAR = 3'd4,
    REG_PUMP_ON   = 3'd5,
    REG_PUMP_OFF  = 3'd6,
    REG_HORN_MAX  = 3'd7
  } reg_index_t;

  localparam int MV_W    = 16;
  localparam int TEMP_W  = 15;
  localparam int MS_W    = 32;
  localparam int DLY_W   = 16;
  localparam int CFG_W   = 16;
  localparam int S_DATA_W = 80;
  localparam int M_DATA_W = 16;

  // switch codes
  localparam logic [1:0] SW_OFF     = 2'd0;
  localparam logic [1:0] SW_ON      = 2'd1;
  localparam logic [1:0] SW_INVALID = 2'd2;

  // trim drive codes (two's complement)
  localparam logic signed [1:0] TRIM_STOP = 2'sd0;
  localparam logic signed [1:0] TRIM_UP   = 2'sd1;
  localparam logic signed [1:0] TRIM_DOWN = -2'sd1;

  localparam logic [MV_W-1:0]          IGN_ON_RST    = 16'd10000;
  localparam logic [MV_W-1:0]          IGN_OFF_RST   = 16'd5000;
  localparam logic [MV_W-1:0]          OVERVOLT_RST  = 16'd18000;
  localparam logic signed [TEMP_W-1:0] HOT_SET_RST   = 15'sd7500;
  localparam logic signed [TEMP_W-1:0] HOT_CLEAR_RST = 15'sd5000;
  localparam logic [DLY_W-1:0]         PUMP_ON_RST   = 16'd1000;
  localparam logic [DLY_W-1:0]         PUMP_OFF_RST  = 16'd3000;
  localparam logic [DLY_W-1:0]         HORN_MAX_RST  = 16'd10000;

  localparam logic [MS_W-1:0] FRESH_SHORT_MS  = 32'd500;
  localparam logic [MS_W-1:0] FRESH_LONG_MS   = 32'd5000;
  localparam logic [MS_W-1:0] SLEEP_DELAY_MS  = 32'd5000;
  localparam logic [MS_W-1:0] TRIM_TIMEOUT_MS = 32'd20000;

  typedef struct packed {
    logic             sleep_ok;
    logic             overtemp_flag;
    logic             overvolt_flag;
    logic             ignition_on;
    logic signed [1:0] trim_drive;
    logic             light_drive;
    logic             aux_drive;
    logic             horn_drive;
    logic             main_drive;
    logic             pump_drive;
  } result_t;

  localparam int RESULT_W = $bits(result_t);

  function automatic logic [1:0] sw_code(input logic [1:0] raw);
    sw_code = (raw == SW_OFF || raw == SW_ON) ? raw : SW_INVALID;
  endfunction

endpackage

[design/power_output_controller.sv]
// Top level of the power output controller: switch state store, control
// step logic and a two-word result queue.
// Depends on pwroc_pkg.

// When an item is accepted, a keypad or trim word updates the stored
// switch states, a control word runs the ignition, temperature, pump, horn,
// trim and light rules in one pass of compare-and-set logic against the
// stored state and pushes one result word. A word can be accepted every cycle;
// s_tready drops only while both entries of the two-word result queue are held
// by a stalled m_tready. A control word's result is queued on acceptance behind
// older words. Configuration writes take effect at the next edge; the user must
// make them only while the block is idle, which the block does not enforce.
module power_output_controller
  import pwroc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // now_ms[31:0], batt_mv[47:32], batt_valid[48], temp_centi[63:49],
  // temp_valid[64], water_high[65], key_a[67:66], key_b[69:68],
  // key_c[71:70], key_d[73:72], zero fill [79:74]
  input  logic [S_DATA_W-1:0] s_tdata,
  // action[1:0]
  input  logic [1:0]          s_tuser,
  output logic                m_tvalid,
  input  logic                m_tready,
  // pump_drive[0], main_drive[1], horn_drive[2], aux_drive[3], light_drive[4],
  // trim_drive[6:5], ignition_on[7], overvolt_flag[8], overtemp_flag[9],
  // sleep_ok[10], zero fill [15:11]
  output logic [M_DATA_W-1:0] m_tdata,
  input  logic                cfg_write,
  input  logic [2:0]          cfg_index,
  input  logic [CFG_W-1:0]    cfg_data
);

  // configuration registers
  logic [MV_W-1:0]          ign_on_mv, ign_off_mv, overvolt_mv;
  logic signed [TEMP_W-1:0] hot_set, hot_clear;
  logic [DLY_W-1:0]         pump_on_dly, pump_off_dly, horn_max;

  // state
  logic            ign_state, overvolt_state, overtemp_state, sleep_state;
  logic [MS_W-1:0] ign_off_time;
  logic [1:0]      key_stat [4];
  logic [1:0]      trim_stat [2];
  logic [MS_W-1:0] key_time, trim_time;
  logic            level_prev, pump_on_state;
  logic [MS_W-1:0] level_time;
  logic            horn_known, horn_prev;
  logic [MS_W-1:0] horn_time;
  logic signed [1:0] trim_prev;
  logic [MS_W-1:0] trim_change;

  // result queue
  result_t    q [2];
  logic       q_wr, q_rd;
  logic [1:0] q_cnt;

  // input fields
  action_t                  action;
  logic [MS_W-1:0]          now_ms;
  logic [MV_W-1:0]          batt_mv;
  logic                     batt_valid, temp_valid, water_high;
  logic signed [TEMP_W-1:0] temp_centi;
  logic [1:0]               key_a, key_b, key_c, key_d;

  assign action     = action_t'(s_tuser);
  assign now_ms     = s_tdata[31:0];
  assign batt_mv    = s_tdata[47:32];
  assign batt_valid = s_tdata[48];
  assign temp_centi = s_tdata[63:49];
  assign temp_valid = s_tdata[64];
  assign water_high = s_tdata[65];
  assign key_a      = s_tdata[67:66];
  assign key_b      = s_tdata[69:68];
  assign key_c      = s_tdata[71:70];
  assign key_d      = s_tdata[73:72];

  logic accept, push, pop;
  assign s_tready = (q_cnt != 2'd2);
  assign accept   = s_tvalid && s_tready;
  assign push     = accept && (action == ACT_CONTROL);
  assign m_tvalid = (q_cnt != 2'd0);
  assign pop      = m_tvalid && m_tready;
  assign m_tdata  = {(M_DATA_W - RESULT_W)'(0), q[q_rd]};

  // control step logic
  logic            ign_next, overvolt_next, overtemp_next, sleep_next;
  logic            ign_fall;
  logic [MS_W-1:0] key_age, trim_age, off_age, level_age, horn_age, trim_hold;
  logic            long_fresh, short_fresh, trim_fresh;
  logic            manual_ok, pump_auto, level, level_chg, pump_on_next;
  logic [DLY_W-1:0] level_dly;
  logic            horn_raw, horn_restart, horn_out, light_out;
  logic signed [1:0] trim_raw, trim_out;
  logic            trim_chg;
  logic            cut_all, cut_hot;
  result_t         res;

  always_comb begin
    ign_next      = ign_state;
    overvolt_next = overvolt_state;
    sleep_next    = sleep_state;
    if (batt_valid) begin
      if (batt_mv > ign_on_mv) begin
        sleep_next = 1'b0;
        ign_next   = 1'b1;
      end
      if (batt_mv < ign_off_mv) ign_next = 1'b0;
      overvolt_next = 1'b0;
      if (batt_mv > overvolt_mv) begin
        ign_next      = 1'b1;
        overvolt_next = 1'b1;
      end
    end
    ign_fall = ign_state && !ign_next;

    overtemp_next = overtemp_state;
    if (temp_valid) begin
      if (overtemp_state && (temp_centi < hot_clear)) overtemp_next = 1'b0;
      if (!overtemp_next && (temp_centi > hot_set)) overtemp_next = 1'b1;
    end

    key_age     = now_ms - key_time;
    trim_age    = now_ms - trim_time;
    long_fresh  = key_age < FRESH_LONG_MS;
    short_fresh = key_age < FRESH_SHORT_MS;
    trim_fresh  = trim_age < FRESH_SHORT_MS;

    // pump: manual only with both pump switches valid and fresh
    manual_ok    = (key_stat[1] != SW_INVALID) && (key_stat[2] != SW_INVALID) && long_fresh;
    pump_auto    = manual_ok ? key_stat[2][0] : 1'b1;
    level        = water_high && ign_next;
    level_chg    = (level != level_prev);
    level_age    = level_chg ? '0 : (now_ms - level_time);
    level_dly    = level ? pump_on_dly : pump_off_dly;
    pump_on_next = pump_on_state;
    if (!pump_auto) begin
      pump_on_next = key_stat[1][0];
    end else if (level_age >= MS_W'(level_dly)) begin
      pump_on_next = level;
    end

    // horn: restart timer on a known off-to-on edge
    horn_raw     = (key_stat[3] == SW_ON) && short_fresh && ign_next;
    horn_restart = horn_raw && horn_known && !horn_prev;
    horn_age     = horn_restart ? '0 : (now_ms - horn_time);
    horn_out     = horn_raw && !(horn_age > MS_W'(horn_max));

    trim_raw = TRIM_STOP;
    if (trim_fresh) begin
      if ((trim_stat[0] == SW_ON) && (trim_stat[1] != SW_INVALID)) trim_raw = TRIM_UP;
      if ((trim_stat[0] != SW_INVALID) && (trim_stat[1] == SW_ON)) trim_raw = TRIM_DOWN;
    end
    trim_chg  = (trim_raw != trim_prev);
    trim_hold = trim_chg ? '0 : (now_ms - trim_change);
    trim_out  = ((trim_hold > TRIM_TIMEOUT_MS) || !ign_next) ? TRIM_STOP : trim_raw;

    light_out = (key_stat[0] == SW_ON) && short_fresh && ign_next;

    // a falling edge restarts the off timer, so it cannot count as expired
    off_age = now_ms - ign_off_time;
    if (!ign_next && !ign_fall && (off_age > SLEEP_DELAY_MS)) sleep_next = 1'b1;

    cut_all = overvolt_next;
    cut_hot = overvolt_next || overtemp_next;

    res.pump_drive    = !cut_hot && pump_on_next && ign_next;
    res.main_drive    = !cut_hot && ign_next;
    res.horn_drive    = !cut_hot && horn_out;
    res.aux_drive     = !cut_all && ign_next;
    res.light_drive   = !cut_all && light_out;
    res.trim_drive    = cut_hot ? TRIM_STOP : trim_out;
    res.ignition_on   = ign_next;
    res.overvolt_flag = overvolt_next;
    res.overtemp_flag = overtemp_next;
    res.sleep_ok      = sleep_next;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ign_on_mv    <= IGN_ON_RST;
      ign_off_mv   <= IGN_OFF_RST;
      overvolt_mv  <= OVERVOLT_RST;
      hot_set      <= HOT_SET_RST;
      hot_clear    <= HOT_CLEAR_RST;
      pump_on_dly  <= PUMP_ON_RST;
      pump_off_dly <= PUMP_OFF_RST;
      horn_max     <= HORN_MAX_RST;
    end else if (cfg_write) begin
      unique case (reg_index_t'(cfg_index))
        REG_IGN_ON:    ign_on_mv    <= cfg_data;
        REG_IGN_OFF:   ign_off_mv   <= cfg_data;
        REG_OVERVOLT:  overvolt_mv  <= cfg_data;
        REG_HOT_SET:   hot_set      <= cfg_data[TEMP_W-1:0];
        REG_HOT_CLEAR: hot_clear    <= cfg_data[TEMP_W-1:0];
        REG_PUMP_ON:   pump_on_dly  <= cfg_data;
        REG_PUMP_OFF:  pump_off_dly <= cfg_data;
        REG_HORN_MAX:  horn_max     <= cfg_data;
        default: ;
      endcase
    end
  end

  // block state
  always_ff @(posedge clk) begin
    if (rst) begin
      ign_state      <= 1'b0;
      ign_off_time   <= '0;
      overvolt_state <= 1'b0;
      overtemp_state <= 1'b0;
      sleep_state    <= 1'b0;
      key_stat[0]    <= SW_INVALID;
      key_stat[1]    <= SW_INVALID;
      key_stat[2]    <= SW_INVALID;
      key_stat[3]    <= SW_INVALID;
      key_time       <= '0;
      trim_stat[0]   <= SW_INVALID;
      trim_stat[1]   <= SW_INVALID;
      trim_time      <= '0;
      level_prev     <= 1'b0;
      level_time     <= '0;
      pump_on_state  <= 1'b0;
      horn_known     <= 1'b0;
      horn_prev      <= 1'b0;
      horn_time      <= '0;
      trim_prev      <= TRIM_STOP;
      trim_change    <= '0;
    end else if (accept) begin
      case (action)
        ACT_KEYPAD: begin
          key_stat[0] <= sw_code(key_a);
          key_stat[1] <= sw_code(key_b);
          key_stat[2] <= sw_code(key_c);
          key_stat[3] <= sw_code(key_d);
          key_time    <= now_ms;
        end
        ACT_TRIM: begin
          trim_stat[0] <= sw_code(key_a);
          trim_stat[1] <= sw_code(key_b);
          trim_time    <= now_ms;
        end
        ACT_CONTROL: begin
          ign_state      <= ign_next;
          overvolt_state <= overvolt_next;
          overtemp_state <= overtemp_next;
          sleep_state    <= sleep_next;
          if (ign_fall) ign_off_time <= now_ms;
          pump_on_state  <= pump_on_next;
          if (pump_auto) begin
            level_prev <= level;
            if (level_chg) level_time <= now_ms;
          end
          horn_known <= 1'b1;
          horn_prev  <= horn_raw;
          if (horn_restart) horn_time <= now_ms;
          trim_prev <= trim_raw;
          if (trim_chg) trim_change <= now_ms;
        end
        default: ;
      endcase
    end
  end

  // result queue: two words, so a stalled word does not block input
  always_ff @(posedge clk) begin
    if (rst) begin
      q_wr  <= 1'b0;
      q_rd  <= 1'b0;
      q_cnt <= 2'd0;
    end else begin
      if (push) q_wr <= ~q_wr;
      if (pop)  q_rd <= ~q_rd;
      q_cnt <= q_cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) q[q_wr] <= res;
  end

`ifndef SYNTHESIS
  a_queue_bound: assert property (@(posedge clk) disable iff (rst) q_cnt != 2'd3)
    else $error("result queue count out of range");

  a_control_result: assert property (@(posedge clk) disable iff (rst)
    push |=> m_tvalid)
    else $error("control word gave no result");

  a_trim_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[6:5] != 2'b10)
    else $error("illegal trim drive code");

  a_overvolt_cut: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[8]) |-> (m_tdata[4:0] == 5'd0 && m_tdata[6:5] == 2'd0))
    else $error("load driven during over-voltage");

  a_ign_gate: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[7]) |-> (m_tdata[4:0] == 5'd0 && m_tdata[6:5] == 2'd0))
    else $error("load driven with ignition off");
`endif

endmodule

[tb/tb_power_output_controller.sv]
// Self-checking testbench for power_output_controller: drives control, keypad and trim words,
// predicts every result word in its own state copy and compares them field by field.
// Depends on pwroc_pkg and the power_output_controller RTL.
module tb_power_output_controller
  import pwroc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] HORN_UNKNOWN = 2'd3;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_SLOW, RX_BURSTY} rx_mode_t;

  typedef struct packed {
    action_t            act;
    logic [31:0]        now_ms;
    logic [15:0]        batt_mv;
    logic               batt_valid;
    logic signed [14:0] temp_centi;
    logic               temp_valid;
    logic               water_high;
    logic [1:0]         key_a;
    logic [1:0]         key_b;
    logic [1:0]         key_c;
    logic [1:0]         key_d;
  } item_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic [1:0]          s_tuser = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  logic                cfg_write = 1'b0;
  logic [2:0]          cfg_index = '0;
  logic [CFG_W-1:0]    cfg_data = '0;

  power_output_controller dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // register copies
  logic [15:0]        lim_ign_on, lim_ign_off, lim_overvolt;
  logic signed [14:0] lim_hot_set, lim_hot_clear;
  logic [15:0]        dly_pump_on, dly_pump_off, dly_horn_max;

  // controller state copy
  logic               ign_latched, ign_last, overvolt_latched, overtemp_latched, sleep_latched;
  logic [31:0]        ign_off_stamp;
  logic [1:0]         keypad_sw [4];
  logic [1:0]         trim_sw [2];
  logic [31:0]        keypad_stamp, trim_stamp;
  logic               pump_in_auto, pump_manual, level_last, pump_running;
  logic [31:0]        level_stamp;
  logic [1:0]         horn_hist;
  logic [31:0]        horn_stamp;
  logic signed [1:0]  trim_last;
  logic [31:0]        trim_stamp_change;

  item_t   pending_words[$];
  result_t expected_results[$];
  item_t   cur_item;
  int      n_pushed = 0, n_issued = 0, n_accepted = 0, n_results = 0, n_errors = 0;
  int      burst_left = 0, gap_left = 0;
  int      rx_cycle = 0, stall_left = 0;
  rx_mode_t rx_mode = RX_OPEN;
  logic [31:0] ms_clock;
  logic        water_pin;

  task automatic report_mismatch(input string msg);
    n_errors++;
    $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [1:0] got, input logic [1:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                n_results, name, got, want));
  endtask

  function automatic logic [1:0] switch_norm(input logic [1:0] raw);
    return raw[1] ? SW_INVALID : raw;
  endfunction

  function automatic result_t control_step(input item_t it);
    result_t           r;
    logic              ign, lvl, pump, horn, light, cut_all, cut_hot;
    logic signed [1:0] trim;
    logic [31:0]       tick, kage, tage, dly;
    tick = it.now_ms;
    if (it.batt_valid) begin
      if (it.batt_mv > lim_ign_on) begin
        sleep_latched = 1'b0;
        ign_latched = 1'b1;
      end
      if (it.batt_mv < lim_ign_off) ign_latched = 1'b0;
      overvolt_latched = 1'b0;
      // over-voltage forces ignition on
      if (it.batt_mv > lim_overvolt) begin
        ign_latched = 1'b1;
        overvolt_latched = 1'b1;
      end
    end
    ign = ign_latched;
    if (ign != ign_last && !ign) ign_off_stamp = tick;
    ign_last = ign;

    // clear test runs before set test
    if (it.temp_valid) begin
      if (overtemp_latched && it.temp_centi < lim_hot_clear) overtemp_latched = 1'b0;
      if (!overtemp_latched && it.temp_centi > lim_hot_set) overtemp_latched = 1'b1;
    end

    lvl = it.water_high & ign;
    kage = tick - keypad_stamp;
    pump_in_auto = 1'b1;
    if (keypad_sw[1] != SW_INVALID && keypad_sw[2] != SW_INVALID && kage < FRESH_LONG_MS) begin
      pump_manual = keypad_sw[1][0];
      pump_in_auto = keypad_sw[2][0];
    end
    if (!pump_in_auto) begin
      pump_running = pump_manual;
    end else begin
      if (lvl != level_last) level_stamp = tick;
      level_last = lvl;
      dly = lvl ? 32'(dly_pump_on) : 32'(dly_pump_off);
      if (tick - level_stamp >= dly) pump_running = lvl;
    end
    pump = pump_running & ign;

    // unknown history after reset: no restart, timer counts from zero
    horn = (keypad_sw[3] == SW_ON && kage < FRESH_SHORT_MS) ? ign : 1'b0;
    if (horn && horn_hist == SW_OFF) horn_stamp = tick;
    horn_hist = horn ? SW_ON : SW_OFF;
    if (tick - horn_stamp > 32'(dly_horn_max)) horn = 1'b0;

    tage = tick - trim_stamp;
    trim = TRIM_STOP;
    if (tage < FRESH_SHORT_MS) begin
      if (trim_sw[0] == SW_ON && trim_sw[1] != SW_INVALID) trim = TRIM_UP;
      if (trim_sw[0] != SW_INVALID && trim_sw[1] == SW_ON) trim = TRIM_DOWN;
    end
    if (trim != trim_last) trim_stamp_change = tick;
    trim_last = trim;
    if (tick - trim_stamp_change > TRIM_TIMEOUT_MS) trim = TRIM_STOP;
    if (!ign) trim = TRIM_STOP;

    light = (keypad_sw[0] == SW_ON && kage < FRESH_SHORT_MS) ? ign : 1'b0;
    if (tick - ign_off_stamp > SLEEP_DELAY_MS && !ign) sleep_latched = 1'b1;

    cut_all = overvolt_latched;
    cut_hot = overvolt_latched | overtemp_latched;
    r.pump_drive    = cut_hot ? 1'b0 : pump;
    r.main_drive    = cut_hot ? 1'b0 : ign;
    r.horn_drive    = cut_hot ? 1'b0 : horn;
    r.aux_drive     = cut_all ? 1'b0 : ign;
    r.light_drive   = cut_all ? 1'b0 : light;
    r.trim_drive    = cut_hot ? TRIM_STOP : trim;
    r.ignition_on   = ign;
    r.overvolt_flag = overvolt_latched;
    r.overtemp_flag = overtemp_latched;
    r.sleep_ok      = sleep_latched;
    return r;
  endfunction

  // Accept input words into the predictor, then check output words.
  always @(posedge clk) begin : monitor
    result_t got, want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        n_accepted++;
        case (cur_item.act)
          ACT_KEYPAD: begin
            keypad_sw[0] = switch_norm(cur_item.key_a);
            keypad_sw[1] = switch_norm(cur_item.key_b);
            keypad_sw[2] = switch_norm(cur_item.key_c);
            keypad_sw[3] = switch_norm(cur_item.key_d);
            keypad_stamp = cur_item.now_ms;
          end
          ACT_TRIM: begin
            trim_sw[0] = switch_norm(cur_item.key_a);
            trim_sw[1] = switch_norm(cur_item.key_b);
            trim_stamp = cur_item.now_ms;
          end
          ACT_CONTROL: expected_results.push_back(control_step(cur_item));
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got = result_t'(m_tdata[RESULT_W-1:0]);
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result word %h with nothing expected", m_tdata));
        end else begin
          want = expected_results.pop_front();
          check_field("pump_drive", got.pump_drive, want.pump_drive);
          check_field("main_drive", got.main_drive, want.main_drive);
          check_field("horn_drive", got.horn_drive, want.horn_drive);
          check_field("aux_drive", got.aux_drive, want.aux_drive);
          check_field("light_drive", got.light_drive, want.light_drive);
          check_field("trim_drive", got.trim_drive, want.trim_drive);
          check_field("ignition_on", got.ignition_on, want.ignition_on);
          check_field("overvolt_flag", got.overvolt_flag, want.overvolt_flag);
          check_field("overtemp_flag", got.overtemp_flag, want.overtemp_flag);
          check_field("sleep_ok", got.sleep_ok, want.sleep_ok);
          if (m_tdata[M_DATA_W-1:RESULT_W] !== '0)
            report_mismatch($sformatf("result %0d fill bits not zero: %h", n_results, m_tdata));
        end
        n_results++;
      end
    end
  end

  // Sender: bursts of words with random gaps; hold a word until it is taken.
  always @(negedge clk) begin : driver
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (n_accepted == n_issued) begin
      if (gap_left != 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (pending_words.size() != 0) begin
        cur_item = pending_words.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= {6'b0, cur_item.key_d, cur_item.key_c, cur_item.key_b, cur_item.key_a,
                    cur_item.water_high, cur_item.temp_valid, cur_item.temp_centi,
                    cur_item.batt_valid, cur_item.batt_mv, cur_item.now_ms};
        s_tuser <= cur_item.act;
        n_issued++;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: stall m_tready in one of four patterns, chosen anew at random.
  always @(negedge clk) begin : receiver
    logic rdy;
    rx_cycle++;
    if (rx_cycle % 300 == 0) rx_mode = rx_mode_t'($urandom_range(0, 3));
    case (rx_mode)
      RX_OPEN:   rdy = 1'b1;
      RX_RANDOM: rdy = ($urandom_range(0, 3) != 0);
      RX_SLOW:   rdy = (rx_cycle % 4 == 0);
      default: begin
        if (stall_left == 0 && $urandom_range(0, 31) == 0) stall_left = $urandom_range(5, 40);
        if (stall_left != 0) begin
          stall_left--;
          rdy = 1'b0;
        end else begin
          rdy = 1'b1;
        end
      end
    endcase
    m_tready <= rdy;
  end

  task automatic push_item(input item_t it);
    pending_words.push_back(it);
    n_pushed++;
  endtask

  task automatic add_directed(input action_t act, input logic [31:0] now,
                              input logic [15:0] batt, input int bv, input int temp,
                              input int tv, input int water, input int a, input int b,
                              input int c, input int d);
    item_t it;
    it.act = act;
    it.now_ms = now;
    it.batt_mv = batt;
    it.batt_valid = 1'(bv);
    it.temp_centi = 15'(temp);
    it.temp_valid = 1'(tv);
    it.water_high = 1'(water);
    it.key_a = 2'(a);
    it.key_b = 2'(b);
    it.key_c = 2'(c);
    it.key_d = 2'(d);
    push_item(it);
  endtask

  function automatic item_t noise_item();
    item_t it;
    it.act = ACT_UNUSED;
    it.now_ms = $urandom;
    it.batt_mv = 16'($urandom);
    it.batt_valid = 1'($urandom);
    it.temp_centi = 15'($urandom);
    it.temp_valid = 1'($urandom);
    it.water_high = 1'($urandom);
    it.key_a = 2'($urandom);
    it.key_b = 2'($urandom);
    it.key_c = 2'($urandom);
    it.key_d = 2'($urandom);
    return it;
  endfunction

  function automatic logic [1:0] rand_key();
    return ($urandom_range(0, 4) == 0) ? 2'($urandom_range(2, 3)) : 2'($urandom_range(0, 1));
  endfunction

  task automatic push_switches(input action_t act, input logic [1:0] a, input logic [1:0] b,
                               input logic [1:0] c, input logic [1:0] d);
    item_t it;
    it = noise_item();
    it.act = act;
    it.now_ms = ms_clock;
    it.key_a = a;
    it.key_b = b;
    it.key_c = c;
    it.key_d = d;
    push_item(it);
  endtask

  task automatic advance_clock();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) ms_clock += $urandom_range(0, 250);
    else if (r < 90) ms_clock += $urandom_range(250, 6000);
    else if (r < 98) ms_clock += $urandom_range(6000, 70000);
    else ms_clock = $urandom;
  endtask

  task automatic push_control();
    item_t it;
    int    t;
    it = noise_item();
    it.act = ACT_CONTROL;
    it.now_ms = ms_clock;
    // aim at the thresholds often
    case ($urandom_range(0, 9))
      0: it.batt_mv = 16'(lim_ign_on + $urandom_range(0, 6) - 3);
      1: it.batt_mv = 16'(lim_ign_off + $urandom_range(0, 6) - 3);
      2: it.batt_mv = 16'(lim_overvolt + $urandom_range(0, 6) - 3);
      3: it.batt_mv = 16'($urandom);
      default: it.batt_mv = 16'($urandom_range(11000, 15000));
    endcase
    it.batt_valid = ($urandom_range(0, 7) != 0);
    case ($urandom_range(0, 9))
      0: t = int'(lim_hot_set) + int'($urandom_range(0, 6)) - 3;
      1: t = int'(lim_hot_clear) + int'($urandom_range(0, 6)) - 3;
      2: t = int'($urandom_range(0, 32767));
      default: t = int'($urandom_range(0, 19000)) - 4000;
    endcase
    it.temp_centi = 15'(t);
    it.temp_valid = ($urandom_range(0, 7) != 0);
    if ($urandom_range(0, 7) == 0) water_pin = ~water_pin;
    it.water_high = water_pin;
    push_item(it);
  endtask

  task automatic run_random(input int n);
    int         done, reps;
    logic [1:0] ka, kb, kc, kd, tu, td;
    done = 0;
    while (done < n) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3: begin
          advance_clock();
          push_switches(ACT_KEYPAD, rand_key(), rand_key(), rand_key(), rand_key());
          done++;
          reps = $urandom_range(1, 5);
          repeat (reps) begin
            ms_clock += $urandom_range(0, 200);
            push_control();
            done++;
          end
        end
        4, 5, 6: begin
          advance_clock();
          push_switches(ACT_TRIM, rand_key(), rand_key(), rand_key(), rand_key());
          done++;
          reps = $urandom_range(1, 4);
          repeat (reps) begin
            ms_clock += $urandom_range(0, 200);
            push_control();
            done++;
          end
        end
        7: begin
          // hold keys and trim fresh long enough to hit the horn and trim time limits
          if ($urandom_range(0, 3) == 0) begin
            ka = 2'($urandom_range(0, 1));
            kb = 2'($urandom_range(0, 1));
            kc = 2'($urandom_range(0, 1));
            kd = ($urandom_range(0, 3) != 0) ? SW_ON : SW_OFF;
            tu = 2'($urandom_range(0, 1));
            td = tu ? 2'($urandom_range(0, 1)) : SW_ON;
            reps = $urandom_range(20, 55);
            repeat (reps) begin
              ms_clock += $urandom_range(100, 480);
              push_switches(ACT_KEYPAD, ka, kb, kc, kd);
              push_switches(ACT_TRIM, tu, td, rand_key(), rand_key());
              push_control();
              done += 3;
            end
          end
        end
        8: push_item(noise_item());
        default: begin
          advance_clock();
          push_control();
          done++;
        end
      endcase
    end
  endtask

  task automatic wait_idle();
    int guard;
    guard = 0;
    while ((n_accepted != n_pushed || expected_results.size() != 0) && guard < 100000) begin
      @(negedge clk);
      guard++;
    end
    if (expected_results.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived", expected_results.size()));
      expected_results.delete();
    end
    // a trailing switch word gives no result; let it settle
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [15:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_IGN_ON:    lim_ign_on = val;
      REG_IGN_OFF:   lim_ign_off = val;
      REG_OVERVOLT:  lim_overvolt = val;
      REG_HOT_SET:   lim_hot_set = val[14:0];
      REG_HOT_CLEAR: lim_hot_clear = val[14:0];
      REG_PUMP_ON:   dly_pump_on = val;
      REG_PUMP_OFF:  dly_pump_off = val;
      REG_HORN_MAX:  dly_horn_max = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input int on, input int off, input int ov, input int hs,
                            input int hc, input int pon, input int poff, input int hmax);
    write_reg(REG_IGN_ON, 16'(on));
    write_reg(REG_IGN_OFF, 16'(off));
    write_reg(REG_OVERVOLT, 16'(ov));
    write_reg(REG_HOT_SET, 16'(hs));
    write_reg(REG_HOT_CLEAR, 16'(hc));
    write_reg(REG_PUMP_ON, 16'(pon));
    write_reg(REG_PUMP_OFF, 16'(poff));
    write_reg(REG_HORN_MAX, 16'(hmax));
    @(negedge clk);
    cfg_write <= 1'b0;
    repeat (2) @(negedge clk);
  endtask

  initial begin : stimulus
    lim_ign_on = IGN_ON_RST;
    lim_ign_off = IGN_OFF_RST;
    lim_overvolt = OVERVOLT_RST;
    lim_hot_set = HOT_SET_RST;
    lim_hot_clear = HOT_CLEAR_RST;
    dly_pump_on = PUMP_ON_RST;
    dly_pump_off = PUMP_OFF_RST;
    dly_horn_max = HORN_MAX_RST;
    ign_latched = 1'b0;
    ign_last = 1'b0;
    ign_off_stamp = '0;
    overvolt_latched = 1'b0;
    overtemp_latched = 1'b0;
    sleep_latched = 1'b0;
    for (int i = 0; i < 4; i++) keypad_sw[i] = SW_INVALID;
    keypad_stamp = '0;
    trim_sw[0] = SW_INVALID;
    trim_sw[1] = SW_INVALID;
    trim_stamp = '0;
    pump_in_auto = 1'b1;
    pump_manual = 1'b0;
    level_last = 1'b0;
    level_stamp = '0;
    pump_running = 1'b0;
    horn_hist = HORN_UNKNOWN;
    horn_stamp = '0;
    trim_last = TRIM_STOP;
    trim_stamp_change = '0;
    water_pin = 1'b0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed words at reset settings
    add_directed(ACT_CONTROL, 0, 16'd0, 1, -4000, 1, 0, 0, 0, 0, 0);
    add_directed(ACT_CONTROL, 100, 16'd12000, 1, 2000, 1, 1, 0, 0, 0, 0);
    add_directed(ACT_KEYPAD, 150, 16'd0, 0, 0, 0, 0, 1, 1, 0, 1);
    // missing samples, horn already on with unknown history
    add_directed(ACT_CONTROL, 200, 16'd0, 0, 0, 0, 1, 0, 0, 0, 0);
    add_directed(ACT_KEYPAD, 10100, 16'd0, 0, 0, 0, 0, 1, 1, 0, 1);
    add_directed(ACT_CONTROL, 10300, 16'd12000, 1, 2000, 1, 1, 0, 0, 0, 0);
    // switch code three stored as invalid
    add_directed(ACT_KEYPAD, 10310, 16'd0, 0, 0, 0, 0, 0, 3, 1, 0);
    add_directed(ACT_TRIM, 10320, 16'd0, 0, 0, 0, 0, 1, 0, 0, 0);
    add_directed(ACT_CONTROL, 10400, 16'd12000, 1, 2000, 1, 1, 0, 0, 0, 0);
    add_directed(ACT_TRIM, 10410, 16'd0, 0, 0, 0, 0, 1, 1, 0, 0);
    add_directed(ACT_CONTROL, 10420, 16'd12000, 1, 2000, 1, 1, 0, 0, 0, 0);
    add_directed(ACT_TRIM, 10430, 16'd0, 0, 0, 0, 0, 3, 1, 0, 0);
    add_directed(ACT_CONTROL, 10440, 16'd12000, 1, 2000, 1, 1, 0, 0, 0, 0);
    add_directed(ACT_CONTROL, 10450, 16'd12000, 1, 16383, 1, 1, 0, 0, 0, 0);
    add_directed(ACT_CONTROL, 10460, 16'd12000, 1, -16384, 1, 1, 0, 0, 0, 0);
    add_directed(ACT_CONTROL, 10470, 16'hFFFF, 1, 2000, 1, 1, 0, 0, 0, 0);
    add_directed(ACT_UNUSED, 10480, 16'hFFFF, 1, -1, 1, 1, 3, 3, 3, 3);
    add_directed(ACT_CONTROL, 10490, 16'd4999, 1, 2000, 1, 0, 0, 0, 0, 0);
    // ignition off long enough for sleep
    add_directed(ACT_CONTROL, 16000, 16'd0, 0, 2000, 1, 0, 0, 0, 0, 0);
    // keypad age across the time wrap
    add_directed(ACT_KEYPAD, 32'hFFFF_FFF0, 16'd0, 0, 0, 0, 0, 1, 0, 0, 1);
    add_directed(ACT_CONTROL, 32'h0000_0010, 16'd12000, 1, 2000, 1, 1, 0, 0, 0, 0);
    // stale keypad
    add_directed(ACT_CONTROL, 32'h0000_2000, 16'd12000, 1, 2000, 1, 1, 0, 0, 0, 0);
    add_directed(ACT_CONTROL, 32'h0000_7000, 16'd12000, 1, 2000, 1, 0, 0, 0, 0, 0);
    ms_clock = 32'h0000_8000;
    run_random(200);
    wait_idle();

    set_config(12500, 11500, 16000, 6000, 5500, 300, 800, 2000);
    run_random(200);
    wait_idle();

    set_config(0, 0, 0, -4000, -4000, 0, 0, 0);
    run_random(120);
    wait_idle();

    set_config(65535, 65535, 65535, 15000, 15000, 65535, 65535, 65535);
    run_random(150);
    wait_idle();

    set_config($urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(0, 65535),
               $urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(0, 3000),
               $urandom_range(0, 3000), $urandom_range(0, 65535));
    run_random(150);
    wait_idle();

    set_config(int'(IGN_ON_RST), int'(IGN_OFF_RST), int'(OVERVOLT_RST), int'(HOT_SET_RST),
               int'(HOT_CLEAR_RST), int'(PUMP_ON_RST), int'(PUMP_OFF_RST),
               int'(HORN_MAX_RST));
    run_random(200);
    wait_idle();

    repeat (8) @(negedge clk);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
